[hw/rtl/mbfr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbfr_pkg
// Shared types and constants of the msb-first bit field reader.
// ----------------------------------------------------------------------------
package mbfr_pkg;

	// fixed field widths of the item ports
	localparam int CMD_W    = 1;
	localparam int BYTE_W   = 8;
	localparam int LEN_W    = 7;
	localparam int VALUE_W  = 64;
	localparam int ADV_W    = 4;
	localparam int STATUS_W = 2;

	// longest field a read may ask for
	localparam int MAX_FIELD_BITS = 64;

	// command codes on the input port
	localparam logic [CMD_W-1:0] CMD_PUSH = 1'b0;
	localparam logic [CMD_W-1:0] CMD_READ = 1'b1;

	// operation after classification in the front part
	typedef enum logic [1:0] {
		OP_PUSH = 2'd0,
		OP_READ = 2'd1,
		OP_SKIP = 2'd2,
		OP_BAD  = 2'd3
	} op_t;

	// result status codes
	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_SHORT = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// one classified item in the queue
	typedef struct packed {
		op_t               op;
		logic [BYTE_W-1:0] data_byte;
		logic [LEN_W-1:0]  field_len;
	} entry_t;

endpackage

[hw/rtl/mbfr_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbfr_front
// Accepts items, classifies the command and length, and holds them in a
// two-entry queue for the back part.
// ----------------------------------------------------------------------------
module mbfr_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [mbfr_pkg::CMD_W-1:0]    command,
	input  logic [mbfr_pkg::BYTE_W-1:0]   data_byte,
	input  logic [mbfr_pkg::LEN_W-1:0]    field_len,
	output logic                          q_valid,
	input  logic                          q_pop,
	output mbfr_pkg::entry_t              q_entry
);
	import mbfr_pkg::*;

	entry_t     ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	entry_t     new_entry;
	logic       push;
	logic       pop;

	// classify the incoming item
	always_comb begin
		new_entry.data_byte = data_byte;
		new_entry.field_len = field_len;
		case (command)
			CMD_PUSH: new_entry.op = OP_PUSH;
			CMD_READ: begin
				if (field_len == '0) begin
					new_entry.op = OP_SKIP;
				end else if (field_len > LEN_W'(MAX_FIELD_BITS)) begin
					new_entry.op = OP_BAD;
				end else begin
					new_entry.op = OP_READ;
				end
			end
			default: new_entry.op = OP_SKIP;
		endcase
	end

	assign in_ready = (count_q != 2'd2);
	assign push     = in_valid && in_ready;
	assign q_valid  = (count_q != 2'd0);
	assign pop      = q_pop && q_valid;
	assign q_entry  = ent_q[rd_ptr_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= new_entry;
		end
	end

	// queue pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[hw/rtl/mbfr_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbfr_back
// Bit buffer with append and barrel-shift extraction; one queued item per
// cycle unless the output stalls; result held in an output register.
// ----------------------------------------------------------------------------
module mbfr_back #(
	parameter int BUFFER_BITS = 128
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           q_valid,
	output logic                           q_pop,
	input  mbfr_pkg::entry_t               q_entry,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [mbfr_pkg::VALUE_W-1:0]   field_value,
	output logic [mbfr_pkg::ADV_W-1:0]     bytes_advanced,
	output logic [mbfr_pkg::STATUS_W-1:0]  status
);
	import mbfr_pkg::*;

	localparam int FILL_W = $clog2(BUFFER_BITS + 1);
	localparam logic [FILL_W-1:0] PUSH_LIMIT = FILL_W'(BUFFER_BITS - BYTE_W);

	logic [BUFFER_BITS-1:0] buf_q;
	logic [FILL_W-1:0]      fill_q;
	logic [2:0]             phase_q;

	logic                   out_valid_q;
	logic [VALUE_W-1:0]     value_q;
	logic [ADV_W-1:0]       adv_q;
	status_t                status_q;

	logic                   take;
	logic [BUFFER_BITS-1:0] byte_placed;
	logic [VALUE_W-1:0]     head;
	logic [LEN_W-1:0]       rshift;
	logic [LEN_W-1:0]       phase_sum;
	logic [ADV_W-1:0]       adv_ceil;
	logic                   is_full;
	logic                   is_short;

	logic [BUFFER_BITS-1:0] buf_d;
	logic [FILL_W-1:0]      fill_d;
	logic [2:0]             phase_d;
	logic [VALUE_W-1:0]     value_d;
	logic [ADV_W-1:0]       adv_d;
	status_t                status_d;

	assign take  = !out_valid_q || out_ready;
	assign q_pop = q_valid && take;

	// datapath: append position, head window, byte advance
	assign byte_placed = {q_entry.data_byte, (BUFFER_BITS - BYTE_W)'(0)} >> fill_q;
	assign head        = buf_q[BUFFER_BITS-1 -: VALUE_W];
	assign rshift      = LEN_W'(VALUE_W) - q_entry.field_len;
	assign phase_sum   = LEN_W'(phase_q) + q_entry.field_len + LEN_W'(7);
	assign adv_ceil    = ADV_W'(phase_sum >> 3);
	assign is_full     = fill_q > PUSH_LIMIT;
	assign is_short    = fill_q < FILL_W'(q_entry.field_len);

	// execute one item
	always_comb begin
		buf_d    = buf_q;
		fill_d   = fill_q;
		phase_d  = phase_q;
		value_d  = '0;
		adv_d    = '0;
		status_d = ST_OK;
		case (q_entry.op)
			OP_PUSH: begin
				if (is_full) begin
					status_d = ST_FULL;
				end else begin
					buf_d  = buf_q | byte_placed;
					fill_d = fill_q + FILL_W'(BYTE_W);
				end
			end
			OP_READ: begin
				if (is_short) begin
					status_d = ST_SHORT;
				end else begin
					value_d = head >> rshift;
					adv_d   = adv_ceil - ADV_W'(phase_q != 3'd0);
					buf_d   = buf_q << q_entry.field_len;
					fill_d  = fill_q - FILL_W'(q_entry.field_len);
					phase_d = phase_q + q_entry.field_len[2:0];
				end
			end
			OP_BAD:  status_d = ST_SHORT;
			default: status_d = ST_OK;
		endcase
	end

	// bit buffer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_q   <= '0;
			fill_q  <= '0;
			phase_q <= 3'd0;
		end else if (q_pop) begin
			buf_q   <= buf_d;
			fill_q  <= fill_d;
			phase_q <= phase_d;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= q_valid;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (q_pop) begin
			value_q  <= value_d;
			adv_q    <= adv_d;
			status_q <= status_d;
		end
	end

	assign out_valid      = out_valid_q;
	assign field_value    = value_q;
	assign bytes_advanced = adv_q;
	assign status         = status_q;

endmodule

[hw/rtl/msb_first_bit_field_reader.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msb_first_bit_field_reader
// MSB-first bitstream reader: push bytes into a bit buffer, read 1..64 bit
// fields with the number of source bytes newly entered.
// ----------------------------------------------------------------------------
// Each item gives exactly one result. Items are taken one per clock cycle
// as long as results are taken; a result appears once its item has been
// accepted into the front queue and reached its head, where the execute
// stage works on it and writes the output register. The throughput is set
// by the execute stage, which appends a byte or extracts a field with
// barrel shifts over the BUFFER_BITS-wide buffer. The two-entry front
// queue lets the input side run on while the output side stalls.
// ----------------------------------------------------------------------------
module msb_first_bit_field_reader #(
	parameter int BUFFER_BITS = 128
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [mbfr_pkg::CMD_W-1:0]     command,
	input  logic [mbfr_pkg::BYTE_W-1:0]    data_byte,
	input  logic [mbfr_pkg::LEN_W-1:0]     field_len,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [mbfr_pkg::VALUE_W-1:0]   field_value,
	output logic [mbfr_pkg::ADV_W-1:0]     bytes_advanced,
	output logic [mbfr_pkg::STATUS_W-1:0]  status
);
	import mbfr_pkg::*;

	logic   q_valid;
	logic   q_pop;
	entry_t q_entry;

	// accept and classify items
	mbfr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.command   (command),
		.data_byte (data_byte),
		.field_len (field_len),
		.q_valid   (q_valid),
		.q_pop     (q_pop),
		.q_entry   (q_entry)
	);

	// execute on the bit buffer
	mbfr_back #(
		.BUFFER_BITS (BUFFER_BITS)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_valid        (q_valid),
		.q_pop          (q_pop),
		.q_entry        (q_entry),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.field_value    (field_value),
		.bytes_advanced (bytes_advanced),
		.status         (status)
	);

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Regression for the msb-first bit field reader. Bytes are pushed and fields
// read through the valid/ready channels. A behavioral copy of the bit buffer
// predicts every result, and results are checked in order, field by field.
// Both channels idle in random bursts. One phase holds the output off until
// the input stalls.
// ----------------------------------------------------------------------------
module tb;
	import mbfr_pkg::*;

	localparam int BUF_BITS       = 128;
	localparam int MAX_PRINTS     = 100;
	localparam int SETTLE_CYCLES  = 8;
	localparam int LONG_HOLD      = 200;
	localparam int RANDOM_ITEMS   = 900;
	localparam int QUIET_ITEMS    = 150;

	// one predicted result
	typedef struct {
		logic [VALUE_W-1:0] value;
		logic [ADV_W-1:0]   advance;
		status_t            st;
	} field_result_t;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	logic [CMD_W-1:0]    command;
	logic [BYTE_W-1:0]   data_byte;
	logic [LEN_W-1:0]    field_len;
	logic                out_valid;
	logic                out_ready;
	logic [VALUE_W-1:0]  field_value;
	logic [ADV_W-1:0]    bytes_advanced;
	logic [STATUS_W-1:0] status;

	// predicted stream state
	logic [BUF_BITS-1:0] stream_bits;
	int                  stream_fill;
	logic [2:0]          stream_phase;
	field_result_t       pending_fields[$];

	int error_count;
	int src_idle_en;
	int sink_idle_en;
	int hold_cycles_left;
	int sink_stall_left;

	msb_first_bit_field_reader #(
		.BUFFER_BITS(BUF_BITS)
	) i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.command       (command),
		.data_byte     (data_byte),
		.field_len     (field_len),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.field_value   (field_value),
		.bytes_advanced(bytes_advanced),
		.status        (status)
	);

	// clock
	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// mismatch report, printing capped so a broken block stays readable
	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		if (error_count < MAX_PRINTS)
			$display("%0t ns: %s mismatch: got 0x%0h, want 0x%0h", $time, what, got, want);
		error_count++;
	endtask

	// advance the predicted stream by one accepted item
	function automatic void predict_field(logic [CMD_W-1:0] cmd, logic [BYTE_W-1:0] byte_in,
			logic [LEN_W-1:0] len);
		field_result_t r;
		int            n;
		r.value   = '0;
		r.advance = '0;
		r.st      = ST_OK;
		n         = int'(len);
		if (cmd == CMD_PUSH) begin
			if (stream_fill + 8 > BUF_BITS) begin
				r.st = ST_FULL;
			end else begin
				stream_bits = stream_bits
					| ({{(BUF_BITS-8){1'b0}}, byte_in} << (BUF_BITS - 8 - stream_fill));
				stream_fill += 8;
			end
		end else if (n == 0) begin
			// zero-length read leaves everything as it is
		end else if (n > MAX_FIELD_BITS || stream_fill < n) begin
			r.st = ST_SHORT;
		end else begin
			r.value      = VALUE_W'(stream_bits >> (BUF_BITS - n));
			r.advance    = ADV_W'((int'(stream_phase) + n + 7) / 8 - (stream_phase != 0 ? 1 : 0));
			stream_bits  = stream_bits << n;
			stream_fill -= n;
			stream_phase = 3'(int'(stream_phase) + n);
		end
		pending_fields.push_back(r);
	endfunction

	// offer one item, hold it until accepted, then predict its result
	task automatic send_item(logic [CMD_W-1:0] cmd, logic [BYTE_W-1:0] byte_in,
			logic [LEN_W-1:0] len);
		if (src_idle_en != 0 && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		in_valid  <= 1'b1;
		command   <= cmd;
		data_byte <= byte_in;
		field_len <= len;
		do @(posedge clk); while (!in_ready);
		predict_field(cmd, byte_in, len);
	endtask

	task automatic send_push(logic [BYTE_W-1:0] byte_in);
		send_item(CMD_PUSH, byte_in, LEN_W'($urandom));
	endtask

	task automatic send_read(int len);
		send_item(CMD_READ, BYTE_W'($urandom), LEN_W'(len));
	endtask

	// stop offering and wait until every predicted result has come back
	task automatic drain_results(int extra);
		in_valid <= 1'b0;
		while (pending_fields.size() != 0) @(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	// result checker and receiver stall generator
	initial begin
		field_result_t want;
		out_ready       <= 1'b0;
		sink_stall_left  = 0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				if (pending_fields.size() == 0) begin
					report_mismatch("unexpected item", field_value, '0);
				end else begin
					want = pending_fields.pop_front();
					if (field_value !== want.value)
						report_mismatch("field_value", field_value, want.value);
					if (bytes_advanced !== want.advance)
						report_mismatch("bytes_advanced", 64'(bytes_advanced), 64'(want.advance));
					if (status !== want.st)
						report_mismatch("status", 64'(status), 64'(want.st));
				end
			end
			if (hold_cycles_left > 0) begin
				hold_cycles_left--;
				out_ready <= 1'b0;
			end else if (sink_stall_left > 0) begin
				sink_stall_left--;
				out_ready <= 1'b0;
			end else if (sink_idle_en != 0 && $urandom_range(0, 7) == 0) begin
				sink_stall_left = $urandom_range(1, 16) - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// extremes of every field, every command and each corner case
	task automatic test_directed_fields();
		logic [7:0] pattern [8] = '{8'hFF, 8'h00, 8'hA5, 8'h80, 8'h01, 8'h7E, 8'hC3, 8'h3C};
		send_read(8);                   // read from an empty buffer
		send_read(0);                   // zero-length read
		foreach (pattern[i]) send_push(pattern[i]);
		send_read(65);                  // just over the longest field
		send_read(127);                 // largest length code
		send_read(1);
		send_read(7);
		send_read(3);
		send_read(64);                  // too few bits left
		send_read(12);
		send_read(1);
		repeat (4) send_push(BYTE_W'($urandom));
		send_read(5);
		send_read(64);                  // full-width field at a nonzero phase
		send_read(3);
		drain_results(SETTLE_CYCLES);
	endtask

	// fill to the top, push into a full buffer, then empty it
	task automatic test_full_buffer();
		while (stream_fill + 8 <= BUF_BITS) send_push(BYTE_W'($urandom));
		repeat (3) send_push(BYTE_W'($urandom));
		while (stream_fill >= MAX_FIELD_BITS) send_read(MAX_FIELD_BITS);
		if (stream_fill > 0) send_read(stream_fill);
		send_read(MAX_FIELD_BITS);
		drain_results(SETTLE_CYCLES);
	endtask

	// receiver holds off long enough for the input side to stall
	task automatic test_input_stall();
		src_idle_en      = 0;
		sink_idle_en     = 0;
		hold_cycles_left = LONG_HOLD;
		repeat (12) begin
			send_push(BYTE_W'($urandom));
			send_read($urandom_range(1, 8));
		end
		// sender pauses here until every result is back
		drain_results(SETTLE_CYCLES);
	endtask

	// random reads and pushes steered by the predicted fill level
	task automatic test_random_stream(int n_items, int idle_on);
		int pick;
		int push_pct;
		int top;
		src_idle_en  = idle_on;
		sink_idle_en = idle_on;
		repeat (n_items) begin
			pick = $urandom_range(0, 99);
			if (stream_fill < 16)
				push_pct = 80;
			else if (stream_fill < 64)
				push_pct = 55;
			else if (stream_fill <= BUF_BITS - 8)
				push_pct = 40;
			else
				push_pct = 15;
			if (pick < 3) begin
				// zero or overlong length
				if ($urandom_range(0, 2) == 0)
					send_read(0);
				else
					send_read($urandom_range(MAX_FIELD_BITS + 1, (1 << LEN_W) - 1));
			end else if ($urandom_range(0, 99) < push_pct) begin
				send_push(BYTE_W'($urandom));
			end else if ($urandom_range(0, 99) < 12 || stream_fill == 0) begin
				send_read($urandom_range(1, MAX_FIELD_BITS));
			end else begin
				top = (stream_fill < MAX_FIELD_BITS) ? stream_fill : MAX_FIELD_BITS;
				if ($urandom_range(0, 9) < 6 && top > 16)
					top = 16;
				send_read($urandom_range(1, top));
			end
		end
		drain_results(SETTLE_CYCLES);
	endtask

	// reset and the sequence of tests
	initial begin
		arst_n           <= 1'b0;
		in_valid         <= 1'b0;
		command          <= CMD_PUSH;
		data_byte        <= '0;
		field_len        <= '0;
		stream_bits       = '0;
		stream_fill       = 0;
		stream_phase      = '0;
		error_count       = 0;
		src_idle_en       = 0;
		sink_idle_en      = 0;
		hold_cycles_left  = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_fields();
		test_full_buffer();
		test_input_stall();
		test_random_stream(RANDOM_ITEMS, 1);
		test_random_stream(QUIET_ITEMS, 0);

		if (error_count == 0) begin
			$display("msb_first_bit_field_reader regression: pass");
		end else begin
			$display("msb_first_bit_field_reader regression: fail");
		end
		$finish;
	end

	// watchdog
	initial begin
		#2000000;
		$display("msb_first_bit_field_reader regression: fail");
		$finish;
	end

endmodule
